// ===== sv/sss_pkg.sv =====
// Package for the seven-segment scan serialiser: shared types, segment and
// digit-select tables, and the constant-reciprocal helpers for digit picking.
// Depends on nothing.
package sss_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned VALUE_W = 14;
    localparam int unsigned PROD_W  = 28;
    localparam int unsigned SHIFT_W = 5;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned COUNT_W = 4;

    localparam logic [VALUE_W-1:0] MAX_SHOWN = 14'd9999;

    // Reciprocal of ten for quotients up to 9999: floor(q * 6554 / 2^16).
    localparam logic [VALUE_W-1:0] TENTH_RECIP = 14'd6554;
    localparam logic [SHIFT_W-1:0] TENTH_SHIFT = 5'd16;

    localparam logic [COUNT_W-1:0] LAST_BIT = 4'd15;

    typedef logic [1:0] pos_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  valid;
        word_t word;
    } item_t;

    function automatic logic [7:0] seg_pattern(input logic [DIGIT_W-1:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'hC0;
            4'd1:    p = 8'hF9;
            4'd2:    p = 8'hA4;
            4'd3:    p = 8'hB0;
            4'd4:    p = 8'h99;
            4'd5:    p = 8'h92;
            4'd6:    p = 8'h82;
            4'd7:    p = 8'hF8;
            4'd8:    p = 8'h80;
            4'd9:    p = 8'h90;
            default: p = 8'hFF;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] select_pattern(input pos_t pos);
        logic [7:0] p;
        case (pos)
            2'd0:    p = 8'hF7;
            2'd1:    p = 8'hFB;
            2'd2:    p = 8'hFD;
            2'd3:    p = 8'hFE;
            default: p = 8'hFE;
        endcase
        return p;
    endfunction

    // Reciprocal and shift that divide a value up to 9999 by the weight of
    // the digit at each scan position.
    function automatic logic [VALUE_W-1:0] place_recip(input pos_t pos);
        logic [VALUE_W-1:0] r;
        case (pos)
            2'd0:    r = 14'd8389;
            2'd1:    r = 14'd5243;
            2'd2:    r = 14'd6554;
            2'd3:    r = 14'd1;
            default: r = 14'd1;
        endcase
        return r;
    endfunction

    function automatic logic [SHIFT_W-1:0] place_shift(input pos_t pos);
        logic [SHIFT_W-1:0] s;
        case (pos)
            2'd0:    s = 5'd23;
            2'd1:    s = 5'd19;
            2'd2:    s = 5'd16;
            2'd3:    s = 5'd0;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/sss_front.sv =====
// Front end of the scan serialiser: accepts refresh ticks, keeps the scan
// position and builds the 16-bit shift word over two pipeline stages.
// Depends on sss_pkg.
module sss_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [13:0]        display_value,
    input  logic               queue_ready,
    output sss_pkg::item_t     item
);

    logic                            ready1;
    logic                            ready2;
    logic                            accept;
    logic [sss_pkg::VALUE_W-1:0]     sat_value;
    logic [sss_pkg::PROD_W-1:0]      place_prod;
    logic [sss_pkg::PROD_W-1:0]      tenth_prod;
    logic [sss_pkg::VALUE_W-1:0]     digit_full;

    sss_pkg::pos_t                   digit_index_reg;
    sss_pkg::pos_t                   digit_index_next;
    logic                            valid1_reg;
    logic                            valid1_next;
    logic [sss_pkg::VALUE_W-1:0]     q1_reg;
    logic [sss_pkg::VALUE_W-1:0]     q1_next;
    sss_pkg::pos_t                   pos1_reg;
    sss_pkg::pos_t                   pos1_next;
    logic                            valid2_reg;
    logic                            valid2_next;
    logic [sss_pkg::VALUE_W-1:0]     q2_reg;
    logic [sss_pkg::VALUE_W-1:0]     q2_next;
    logic [sss_pkg::VALUE_W-1:0]     t2_reg;
    logic [sss_pkg::VALUE_W-1:0]     t2_next;
    sss_pkg::pos_t                   pos2_reg;
    sss_pkg::pos_t                   pos2_next;

    assign ready2 = !valid2_reg || queue_ready;
    assign ready1 = !valid1_reg || ready2;
    assign full   = !ready1;
    assign accept = push && ready1;

    assign sat_value  = (display_value > sss_pkg::MAX_SHOWN) ? sss_pkg::MAX_SHOWN
                                                             : display_value;
    assign place_prod = {14'd0, sat_value} * {14'd0, sss_pkg::place_recip(digit_index_reg)};
    assign tenth_prod = {14'd0, q1_reg} * {14'd0, sss_pkg::TENTH_RECIP};
    assign digit_full = q2_reg - ((t2_reg << 3) + (t2_reg << 1));

    always_comb
    begin
        digit_index_next = accept ? digit_index_reg + 2'd1 : digit_index_reg;
        valid1_next      = ready1 ? push : valid1_reg;
        q1_next          = accept
                         ? sss_pkg::VALUE_W'(place_prod >> sss_pkg::place_shift(digit_index_reg))
                         : q1_reg;
        pos1_next        = accept ? digit_index_reg : pos1_reg;
        valid2_next      = ready2 ? valid1_reg : valid2_reg;
        q2_next          = ready2 ? q1_reg : q2_reg;
        t2_next          = ready2 ? sss_pkg::VALUE_W'(tenth_prod >> sss_pkg::TENTH_SHIFT)
                                  : t2_reg;
        pos2_next        = ready2 ? pos1_reg : pos2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_index_reg <= 2'd0;
            valid1_reg      <= 1'b0;
            valid2_reg      <= 1'b0;
        end
        else
        begin
            digit_index_reg <= digit_index_next;
            valid1_reg      <= valid1_next;
            valid2_reg      <= valid2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q1_reg   <= q1_next;
        pos1_reg <= pos1_next;
        q2_reg   <= q2_next;
        t2_reg   <= t2_next;
        pos2_reg <= pos2_next;
    end

    assign item.valid = valid2_reg;
    assign item.word  = {sss_pkg::seg_pattern(digit_full[sss_pkg::DIGIT_W-1:0]),
                         sss_pkg::select_pattern(pos2_reg)};

endmodule

// ===== sv/sss_fifo.sv =====
// Two-entry queue of shift words between the front end and the shifter.
// Depends on sss_pkg.
module sss_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  sss_pkg::item_t     wr_item,
    output logic               wr_ready,
    output sss_pkg::item_t     rd_item,
    input  logic               rd_take
);

    sss_pkg::word_t  mem_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            do_write;
    logic            do_read;

    assign wr_ready = (count_reg != 2'd2);
    assign do_write = wr_item.valid && wr_ready;
    assign do_read  = rd_take && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = do_write ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_read ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_write} - {1'b0, do_read};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem_reg[wr_ptr_reg] <= wr_item.word;
        end
    end

    assign rd_item.valid = (count_reg != 2'd0);
    assign rd_item.word  = mem_reg[rd_ptr_reg];

endmodule

// ===== sv/sss_back.sv =====
// Back end of the scan serialiser: loads shift words from the queue and
// presents them one bit per transfer, flagging the sixteenth bit.
// Depends on sss_pkg.
module sss_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  sss_pkg::item_t     rd_item,
    output logic               rd_take,
    output logic               empty,
    input  logic               pop,
    output logic               serial_bit,
    output logic               latch_after
);

    sss_pkg::word_t                shift_reg;
    sss_pkg::word_t                shift_next;
    logic [sss_pkg::COUNT_W-1:0]   count_reg;
    logic [sss_pkg::COUNT_W-1:0]   count_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic                          last_bit;
    logic                          moved;

    assign last_bit = (count_reg == sss_pkg::LAST_BIT);
    assign moved    = pop && valid_reg;
    assign rd_take  = rd_item.valid && (!valid_reg || (moved && last_bit));

    always_comb
    begin
        shift_next = shift_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        if (rd_take)
        begin
            shift_next = rd_item.word;
            count_next = '0;
            valid_next = 1'b1;
        end
        else if (moved)
        begin
            shift_next = shift_reg << 1;
            count_next = count_reg + 4'd1;
            valid_next = !last_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign empty       = !valid_reg;
    assign serial_bit  = shift_reg[sss_pkg::WORD_W-1];
    assign latch_after = valid_reg && last_bit;

`ifndef SYNTH
    a_word_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (moved && !last_bit) |=> (valid_reg && count_reg == $past(count_reg) + 4'd1))
        else $error("bits of one word were not presented back to back");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        rd_take |-> (!valid_reg || (moved && last_bit)))
        else $error("a new word was loaded over an unfinished one");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !pop) |=> ($stable(shift_reg) && $stable(count_reg) && valid_reg))
        else $error("shifter moved while the receiver stalled");
`endif

endmodule

// ===== sv/seven_segment_scan_serializer.sv =====
// Four-digit multiplexed seven-segment scan serialiser, top level.
// Depends on sss_pkg, sss_front, sss_fifo and sss_back.
//
// Input queue: display_value is transferred when push is high and full is low.
// Each transfer is one refresh tick; the value saturates at 9999 and the digit
// at the current scan position (thousands first) is shown.
// Output queue: while empty is low, serial_bit holds the next bit for the
// chained shift registers, segment byte then digit-select byte, MSB first.
// A bit is transferred when pop is high and empty is low; latch_after is high
// on the sixteenth bit of each tick.
// The first bit of a tick passes both front-end stages, the queue and the
// output shift register before it appears. Throughput: one bit per cycle
// when pop is held high, set by the single output shift register.
// The front end holds up to two ticks in flight and the queue two more, so
// further ticks are taken while bits are still being shifted out.
// Reset clears the scan position to the leftmost digit and empties every
// stage. When the receiver stalls, the current bit holds and full rises
// once the front end and queue are both occupied.
module seven_segment_scan_serializer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [13:0] display_value,
    output logic        empty,
    input  logic        pop,
    output logic        serial_bit,
    output logic        latch_after
);

    sss_pkg::item_t  front_item;
    sss_pkg::item_t  queue_item;
    logic            queue_ready;
    logic            queue_take;

    sss_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .display_value (display_value),
        .queue_ready   (queue_ready),
        .item          (front_item)
    );

    sss_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (front_item),
        .wr_ready (queue_ready),
        .rd_item  (queue_item),
        .rd_take  (queue_take)
    );

    sss_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_item     (queue_item),
        .rd_take     (queue_take),
        .empty       (empty),
        .pop         (pop),
        .serial_bit  (serial_bit),
        .latch_after (latch_after)
    );

endmodule
